// ===== src/indexed_packet_reassembler_macros.svh =====
// Assertion macros shared by the reassembler modules.
`ifndef INDEXED_PACKET_REASSEMBLER_MACROS_SVH
`define INDEXED_PACKET_REASSEMBLER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define IPR_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define IPR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define IPR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ipr_pkg.sv =====
// Shared types and constants of the indexed packet reassembler.
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

    // Widths of the item fields.
    localparam int IDX_W       = 8;
    localparam int DLEN_W      = 4;
    localparam int RADDR_W     = 7;
    localparam int BYTE_W      = 8;
    localparam int BYTE_LANES  = 8;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int OP_W        = 2;
    localparam int LANE_SEL_W  = 3;

    // Packed input item layout.
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_DLEN_LSB  = IN_IDX_LSB + IDX_W;
    localparam int IN_RADDR_LSB = IN_DLEN_LSB + DLEN_W;
    localparam int IN_BYTE_LSB  = IN_RADDR_LSB + RADDR_W;
    localparam int IN_USED_W    = IN_BYTE_LSB + BYTE_LANES * BYTE_W;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    // Packed result item layout.
    localparam int OUT_USED_W = 1 + 1 + CNT_W + BYTE_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Operation codes carried in tuser.
    typedef enum logic [OP_W-1:0] {
        OP_PACKET = 2'd0,
        OP_UNLOCK = 2'd1,
        OP_RESET  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PKG_IDX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RCV_LEN     = 8'd1;

    // Reset values.
    localparam logic [IDX_W-1:0]      RST_MAX_PKG_IDX = 8'd255;
    localparam logic [CFG_DATA_W-1:0] RST_RCV_LEN     = 8'd0;
    localparam logic [IDX_W-1:0]      FIRST_IDX       = 8'd1;

    // Result handed from the controller to the output stage.
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [CNT_W-1:0]  received_count;
        logic              finished;
        logic              confirm;
    } t_result;

endpackage

`default_nettype wire

// ===== src/indexed_packet_reassembler.sv =====
// Top level of the indexed packet reassembler.
//
//  channel   direction  handshake                        payload
//  s_axis    in         s_axis_tvalid / s_axis_tready    tdata: index, length, address, bytes;
//                                                        tuser: operation
//  m_axis    out        m_axis_tvalid / m_axis_tready    tdata: confirm, finished, count, byte
//  cfg       in         i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
//  A packet stores its n bytes (0 to 8) one at a time through the single write port
//  of the payload store; resync, unlock, reset and read items store nothing.
//  A new item is accepted while the previous result waits in the output register.
//  A stalled output holds the result and stops the next one from leaving the controller.
//  Reset restores counters, confirm, finished and configuration; the store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module indexed_packet_reassembler #(
    parameter int BUF_DEPTH    = 128,
    parameter int PACKET_BYTES = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // tdata: package_index, data_len, read_address, byte_0 .. byte_7 (bit 0 up)
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic      [ipr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: operation
    input  wire logic      [ipr_pkg::OP_W-1:0]      s_axis_tuser,
    // tdata: confirm, finished, received_count, read_data (bit 0 up)
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic           [ipr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic      [ipr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic      [ipr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ipr_pkg::*;

    localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic              wr_en, rd_en, load, can_load;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [BYTE_W-1:0] wr_data, rd_data;
    t_result           result;

    ipr_ctrl #(
        .BUF_DEPTH    (BUF_DEPTH),
        .PACKET_BYTES (PACKET_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_load      (load),
        .o_result    (result),
        .i_can_load  (can_load)
    );

    ipr_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (BUF_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ipr_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_result   (result),
        .o_can_load (can_load),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== src/ipr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ipr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/ipr_out.sv =====
// Output register stage of the reassembler result stream.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_packet_reassembler_macros.svh"

module ipr_out (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_load,
    input  wire ipr_pkg::t_result                  i_result,
    output logic                                   o_can_load,
    output logic                                   o_tvalid,
    input  wire logic                              i_tready,
    output logic      [ipr_pkg::OUT_DATA_W-1:0]    o_tdata
);
    import ipr_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Take a new result when empty or when the held one leaves this cycle.
    assign o_can_load = !r_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload until it is taken.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    // Pack: confirm, finished, received_count, read_data from bit 0 up.
    assign o_tvalid = r_valid;
    assign o_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                       r_result.read_data, r_result.received_count,
                       r_result.finished, r_result.confirm};

    `IPR_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, i_load, o_can_load, "result overwritten")
    `IPR_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, i_load, r_valid, "loaded result not shown")

endmodule

`default_nettype wire

// ===== src/ipr_ctrl.sv =====
// Packet decision, state counters and store write sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_packet_reassembler_macros.svh"

module ipr_ctrl #(
    parameter int BUF_DEPTH    = 128,
    parameter int PACKET_BYTES = 8,
    parameter int ADDR_W       = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input items
    input  wire logic                              i_tvalid,
    output logic                                   o_tready,
    input  wire logic      [ipr_pkg::IN_DATA_W-1:0] i_tdata,
    input  wire logic      [ipr_pkg::OP_W-1:0]     i_tuser,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic      [ipr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic      [ipr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // payload store
    output logic                                   o_wr_en,
    output logic           [ADDR_W-1:0]            o_wr_addr,
    output logic           [ipr_pkg::BYTE_W-1:0]   o_wr_data,
    output logic                                   o_rd_en,
    output logic           [ADDR_W-1:0]            o_rd_addr,
    input  wire logic      [ipr_pkg::BYTE_W-1:0]   i_rd_data,
    // result hand-off
    output logic                                   o_load,
    output ipr_pkg::t_result                       o_result,
    input  wire logic                              i_can_load
);
    import ipr_pkg::*;

    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(BUF_DEPTH);
    localparam logic [DLEN_W-1:0] LANES_C = DLEN_W'(PACKET_BYTES);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WRITE = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_max_idx, n_max_idx;
    logic [CFG_DATA_W-1:0] r_rlen, n_rlen;
    logic [IDX_W-1:0]     r_exp, n_exp;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic                 r_confirm, n_confirm;
    logic                 r_done, n_done;
    logic                 r_rd_ok, n_rd_ok;
    logic [CNT_W-1:0]     r_base, n_base;
    logic [DLEN_W-1:0]    r_take, n_take;
    logic [LANE_SEL_W-1:0] r_cnt, n_cnt;
    logic [BYTE_W-1:0]    r_bytes [BYTE_LANES];

    // Unpacked input fields.
    logic [IDX_W-1:0]     pkt_idx;
    logic [DLEN_W-1:0]    pkt_dlen;
    logic [RADDR_W-1:0]   pkt_raddr;
    logic [BYTE_W-1:0]    pkt_bytes [BYTE_LANES];
    t_op                  op;

    assign pkt_idx   = i_tdata[IN_IDX_LSB +: IDX_W];
    assign pkt_dlen  = i_tdata[IN_DLEN_LSB +: DLEN_W];
    assign pkt_raddr = i_tdata[IN_RADDR_LSB +: RADDR_W];
    assign op        = t_op'(i_tuser);

    always_comb begin
        for (int k = 0; k < BYTE_LANES; k++) begin
            pkt_bytes[k] = i_tdata[IN_BYTE_LSB + k * BYTE_W +: BYTE_W];
        end
    end

    // Handshakes: configuration wins when both arrive together.
    logic s_fire, cfg_fire;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_tready    = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign s_fire      = i_tvalid && o_tready;

    // Packet classification against the current state.
    logic             is_resync, is_final, is_hit, is_restart, pkt_take;
    logic [CNT_W-1:0] eff_len, base, remaining;
    logic [DLEN_W-1:0] dlen_c, take;
    logic [IDX_W-1:0] exp_base;

    assign is_resync  = (pkt_idx == r_max_idx);
    assign is_final   = (pkt_idx == '0) && (r_exp > FIRST_IDX);
    assign is_hit     = (pkt_idx == r_exp);
    assign is_restart = (pkt_idx == FIRST_IDX) && (r_exp > FIRST_IDX);
    assign pkt_take   = !is_resync && !r_done && (is_final || is_hit || is_restart);

    // Clamp the byte count to the lane count and the space left.
    assign dlen_c    = (pkt_dlen > LANES_C) ? LANES_C : pkt_dlen;
    assign eff_len   = (r_rlen > DEPTH_C) ? DEPTH_C : r_rlen;
    assign base      = is_restart ? '0 : r_fill;
    assign exp_base  = is_restart ? FIRST_IDX : r_exp;
    assign remaining = (base < eff_len) ? (eff_len - base) : '0;
    assign take      = (remaining < CNT_W'(dlen_c)) ? remaining[DLEN_W-1:0] : dlen_c;

    // Read address check against the store depth.
    logic addr_ok;
    logic [CNT_W-1:0] raddr_ext;
    assign raddr_ext = CNT_W'(pkt_raddr);
    assign addr_ok   = (raddr_ext < DEPTH_C);

    // Write sequencer address and lane.
    logic [CNT_W-1:0] wr_pos;
    logic             wr_last;
    assign wr_pos  = r_base + CNT_W'(r_cnt);
    assign wr_last = ({1'b0, r_cnt} == (r_take - DLEN_W'(1)));

    always_comb begin
        n_state   = r_state;
        n_max_idx = r_max_idx;
        n_rlen    = r_rlen;
        n_exp     = r_exp;
        n_fill    = r_fill;
        n_confirm = r_confirm;
        n_done    = r_done;
        n_rd_ok   = r_rd_ok;
        n_base    = r_base;
        n_take    = r_take;
        n_cnt     = r_cnt;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        o_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    // Writes of a new resync index or of the length restart the transfer.
                    case (i_cfg_index)
                        REG_MAX_PKG_IDX: begin
                            if (i_cfg_data != r_max_idx) begin
                                n_max_idx = i_cfg_data;
                                n_exp     = FIRST_IDX;
                                n_fill    = '0;
                                n_confirm = 1'b0;
                            end
                        end
                        REG_RCV_LEN: begin
                            n_rlen = i_cfg_data;
                            n_exp  = FIRST_IDX;
                            n_fill = '0;
                            n_done = 1'b0;
                        end
                        default: ;
                    endcase
                end else if (s_fire) begin
                    n_rd_ok = 1'b0;
                    n_state = S_DONE;
                    case (op)
                        OP_PACKET: begin
                            if (is_resync) begin
                                n_confirm = !r_confirm;
                                n_exp     = FIRST_IDX;
                                n_fill    = '0;
                                n_done    = 1'b0;
                            end else if (pkt_take) begin
                                n_confirm = !r_confirm;
                                n_exp     = exp_base + IDX_W'(1);
                                n_fill    = base + CNT_W'(take);
                                n_done    = r_done || is_final;
                                n_base    = base;
                                n_take    = take;
                                n_cnt     = '0;
                                if (take != '0) begin
                                    n_state = S_WRITE;
                                end
                            end
                        end
                        OP_UNLOCK: begin
                            if (r_done) begin
                                n_exp  = FIRST_IDX;
                                n_fill = '0;
                                n_done = 1'b0;
                            end
                        end
                        OP_RESET: begin
                            n_exp     = FIRST_IDX;
                            n_fill    = '0;
                            n_confirm = 1'b0;
                        end
                        OP_READ: begin
                            o_rd_en = addr_ok;
                            n_rd_ok = addr_ok;
                        end
                        default: ;
                    endcase
                end
            end
            S_WRITE: begin
                // Store one payload byte per cycle.
                o_wr_en = 1'b1;
                n_cnt   = r_cnt + LANE_SEL_W'(1);
                if (wr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result over once the output stage has room.
                if (i_can_load) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_wr_addr = wr_pos[ADDR_W-1:0];
    assign o_wr_data = r_bytes[r_cnt];
    assign o_rd_addr = raddr_ext[ADDR_W-1:0];

    assign o_result = '{read_data:      (r_rd_ok ? i_rd_data : '0),
                        received_count: r_fill,
                        finished:       r_done,
                        confirm:        r_confirm};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max_idx <= RST_MAX_PKG_IDX;
            r_rlen    <= RST_RCV_LEN;
            r_exp     <= FIRST_IDX;
            r_fill    <= '0;
            r_confirm <= 1'b0;
            r_done    <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_cnt     <= '0;
            r_take    <= '0;
        end else begin
            r_state   <= n_state;
            r_max_idx <= n_max_idx;
            r_rlen    <= n_rlen;
            r_exp     <= n_exp;
            r_fill    <= n_fill;
            r_confirm <= n_confirm;
            r_done    <= n_done;
            r_rd_ok   <= n_rd_ok;
            r_cnt     <= n_cnt;
            r_take    <= n_take;
        end
    end

    // Latch the payload of an accepted item.
    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        if (s_fire) begin
            for (int k = 0; k < BYTE_LANES; k++) begin
                r_bytes[k] <= pkt_bytes[k];
            end
        end
    end

    `IPR_ASSERT(a_fill_in_range, i_clk, i_rst_n, (r_fill <= eff_len), "fill beyond length")
    `IPR_ASSERT_IMPL(a_write_count, i_clk, i_rst_n, (r_state == S_WRITE), ({1'b0, r_cnt} < r_take), "write count past take")
    `IPR_ASSERT_NEXT(a_read_to_done, i_clk, i_rst_n, (s_fire && (op == OP_READ)), (r_state == S_DONE), "read did not finish")

endmodule

`default_nettype wire

// ===== tb/sv/ipr_checker.sv =====
// Checker that predicts the reassembler's status items and compares them on the output channel.
`timescale 1ns / 1ps

module ipr_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_item_valid,
    input  logic                              i_item_ready,
    input  logic [ipr_pkg::IN_DATA_W-1:0]     i_item_data,
    input  logic [ipr_pkg::OP_W-1:0]          i_item_op,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic [ipr_pkg::OUT_DATA_W-1:0]    i_res_data,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [ipr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ipr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);
    import ipr_pkg::*;

    localparam int STORE_DEPTH = 128;

    // Shadow of the receiver: registers, counters and payload store
    logic [IDX_W-1:0]      resync_idx;
    logic [CFG_DATA_W-1:0] want_len;
    logic [IDX_W-1:0]      next_idx;
    logic [CNT_W-1:0]      fill_pos;
    logic                  conf_bit;
    logic                  done_bit;
    logic [BYTE_W-1:0]     store [STORE_DEPTH];
    t_result               status_q [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic flag_error(input string what, input int got, input int want);
        $display("ERROR %0t ns: %s: got %0d, want %0d", $time, what, got, want);
        o_errors++;
    endtask

    function automatic void restart_fill();
        next_idx = FIRST_IDX;
        fill_pos = '0;
    endfunction

    // Advance the shadow state by one input item and return the status it leaves
    function automatic t_result apply_item(input t_op op, input logic [IN_DATA_W-1:0] d);
        t_result           res;
        logic [IDX_W-1:0]  idx;
        logic [RADDR_W-1:0] addr;
        logic              take_it;
        int                len;
        int                limit;
        int                room;
        int                n;
        idx  = d[IN_IDX_LSB +: IDX_W];
        addr = d[IN_RADDR_LSB +: RADDR_W];
        len  = int'(d[IN_DLEN_LSB +: DLEN_W]);
        res.read_data = '0;
        case (op)
            OP_PACKET: begin
                if (idx == resync_idx) begin
                    // resync: toggle confirm and start over
                    conf_bit = ~conf_bit;
                    restart_fill();
                    done_bit = 1'b0;
                end else if (!done_bit) begin
                    take_it = 1'b1;
                    if (idx == '0 && next_idx > FIRST_IDX) begin
                        done_bit = 1'b1;
                    end else if (idx == next_idx) begin
                        take_it = 1'b1;
                    end else if (idx == FIRST_IDX && next_idx > FIRST_IDX) begin
                        restart_fill();
                    end else begin
                        take_it = 1'b0;
                    end
                    if (take_it) begin
                        // clamp to the packet size and to the room left in the buffer
                        if (len > BYTE_LANES) len = BYTE_LANES;
                        limit = (int'(want_len) > STORE_DEPTH) ? STORE_DEPTH : int'(want_len);
                        room  = (int'(fill_pos) < limit) ? limit - int'(fill_pos) : 0;
                        n     = (room < len) ? room : len;
                        for (int i = 0; i < n; i++)
                            store[int'(fill_pos) + i] = d[IN_BYTE_LSB + BYTE_W*i +: BYTE_W];
                        next_idx = next_idx + 1'b1;
                        fill_pos = fill_pos + CNT_W'(n);
                        conf_bit = ~conf_bit;
                    end
                end
            end
            OP_UNLOCK: begin
                if (done_bit) begin
                    restart_fill();
                    done_bit = 1'b0;
                end
            end
            OP_RESET: begin
                restart_fill();
                conf_bit = 1'b0;
            end
            default: begin
                if (int'(addr) < STORE_DEPTH) res.read_data = store[addr];
            end
        endcase
        res.confirm        = conf_bit;
        res.finished       = done_bit;
        res.received_count = fill_pos;
        return res;
    endfunction

    // Track register writes and items, compare each status item with the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            resync_idx = RST_MAX_PKG_IDX;
            want_len   = RST_RCV_LEN;
            restart_fill();
            conf_bit   = 1'b0;
            done_bit   = 1'b0;
            status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_MAX_PKG_IDX) begin
                    if (i_cfg_data != resync_idx) begin
                        resync_idx = i_cfg_data;
                        restart_fill();
                        conf_bit = 1'b0;
                    end
                end else if (i_cfg_index == REG_RCV_LEN) begin
                    want_len = i_cfg_data;
                    restart_fill();
                    done_bit = 1'b0;
                end
            end
            if (i_item_valid && i_item_ready)
                status_q.push_back(apply_item(t_op'(i_item_op), i_item_data));
            if (i_res_valid && i_res_ready) begin
                got = t_result'(i_res_data[OUT_USED_W-1:0]);
                if (status_q.size() == 0) begin
                    flag_error("status item with none pending", int'(got), 0);
                end else begin
                    want = status_q.pop_front();
                    if (got.confirm != want.confirm)
                        flag_error("confirm", int'(got.confirm), int'(want.confirm));
                    if (got.finished != want.finished)
                        flag_error("finished", int'(got.finished), int'(want.finished));
                    if (got.received_count != want.received_count)
                        flag_error("received_count", int'(got.received_count),
                                   int'(want.received_count));
                    if (got.read_data != want.read_data)
                        flag_error("read_data", int'(got.read_data), int'(want.read_data));
                end
            end
        end
        o_pending <= status_q.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the reassembler testbench: clock, reset, stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
    import ipr_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int n_sent = 0;
    int n_recv = 0;
    int quiet_run = 0;
    int err_count;
    int pending_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    indexed_packet_reassembler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ipr_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .i_item_ready (s_axis_tready),
        .i_item_data  (s_axis_tdata),
        .i_item_op    (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (err_count),
        .o_pending    (pending_count)
    );

    // Count status items taken from the block
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) n_recv <= n_recv + 1;
    end

    // Pack one input item with a random payload
    function automatic logic [IN_DATA_W-1:0] make_item(input logic [IDX_W-1:0] idx,
                                                       input logic [DLEN_W-1:0] dlen,
                                                       input logic [RADDR_W-1:0] addr);
        logic [IN_DATA_W-1:0] v;
        v = '0;
        v[IN_IDX_LSB +: IDX_W]     = idx;
        v[IN_DLEN_LSB +: DLEN_W]   = dlen;
        v[IN_RADDR_LSB +: RADDR_W] = addr;
        v[IN_BYTE_LSB +: BYTE_LANES*BYTE_W] = {$urandom, $urandom};
        return v;
    endfunction

    // Fully random item fields, for items whose fields do not matter
    function automatic logic [IN_DATA_W-1:0] rand_item();
        return make_item(IDX_W'($urandom), DLEN_W'($urandom), RADDR_W'($urandom));
    endfunction

    // Mostly legal lengths, now and then an oversized one
    function automatic logic [DLEN_W-1:0] pick_len();
        if ($urandom_range(0, 99) < 6) return DLEN_W'($urandom_range(9, 15));
        return DLEN_W'($urandom_range(0, 8));
    endfunction

    // Sender gap: mostly short, a few long, sometimes a run of back-to-back items
    function automatic int pick_gap();
        int r;
        if (quiet_run > 0) begin
            quiet_run--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet_run = 30;
            return 0;
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic send_item(input t_op op, input logic [IN_DATA_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    // Hold the input until every status item has come back
    task automatic drain();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        while (n_recv != n_sent) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write both registers in random order while the block is idle
    task automatic configure(input logic [IDX_W-1:0] resync, input logic [CFG_DATA_W-1:0] len);
        drain();
        if ($urandom_range(0, 1)) begin
            write_reg(REG_MAX_PKG_IDX, resync);
            write_reg(REG_RCV_LEN, len);
        end else begin
            write_reg(REG_RCV_LEN, len);
            write_reg(REG_MAX_PKG_IDX, resync);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Output back-pressure: bursts of ready, short and long stalls, one very long hold
    initial begin
        int  burst;
        int  stall;
        int  r;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            r = $urandom_range(0, 99);
            burst = (r < 10) ? $urandom_range(100, 300) : $urandom_range(1, 8);
            m_axis_tready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            if (!long_hold_done && n_recv >= 600) begin
                long_hold_done = 1'b1;
                stall = 400;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40)      stall = 0;
                else if (r < 80) stall = $urandom_range(1, 3);
                else if (r < 95) stall = $urandom_range(4, 10);
                else             stall = $urandom_range(20, 50);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        int               phase;
        int               r;
        int               count;
        logic [IDX_W-1:0] seq;
        logic [IDX_W-1:0] resync;
        logic [CFG_DATA_W-1:0] len;
        bit               fin;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill the whole buffer first so that every later read hits a written byte
        configure(RST_MAX_PKG_IDX, 8'd128);
        for (int k = 1; k <= 16; k++)
            send_item(OP_PACKET, make_item(IDX_W'(k), 4'd8, RADDR_W'($urandom)));
        // buffer full: a further packet stores nothing
        send_item(OP_PACKET, make_item(8'd17, 4'd8, RADDR_W'($urandom)));
        send_item(OP_READ, make_item(IDX_W'($urandom), DLEN_W'($urandom), 7'd0));
        send_item(OP_READ, make_item(IDX_W'($urandom), DLEN_W'($urandom), 7'd127));
        // final packet, then a packet ignored while finished, then unlock twice
        send_item(OP_PACKET, make_item(8'd0, 4'd8, RADDR_W'($urandom)));
        send_item(OP_PACKET, make_item(8'd18, 4'd8, RADDR_W'($urandom)));
        send_item(OP_UNLOCK, rand_item());
        send_item(OP_UNLOCK, rand_item());
        // oversized length, an unexpected index, an empty packet, a mid-transfer restart
        send_item(OP_PACKET, make_item(8'd1, 4'd15, RADDR_W'($urandom)));
        send_item(OP_PACKET, make_item(8'd5, 4'd8, RADDR_W'($urandom)));
        send_item(OP_PACKET, make_item(8'd2, 4'd0, RADDR_W'($urandom)));
        send_item(OP_PACKET, make_item(8'd1, 4'd8, RADDR_W'($urandom)));
        send_item(OP_RESET, rand_item());
        send_item(OP_PACKET, make_item(8'd255, 4'd8, RADDR_W'($urandom)));
        send_item(OP_READ, make_item(IDX_W'($urandom), DLEN_W'($urandom), 7'd64));

        phase = 0;
        while (n_sent < 2030) begin
            phase++;
            if (phase == 3) begin
                // resync index 0 lets a clean run wrap the expected index past 255
                configure(8'd0, 8'd255);
                seq = FIRST_IDX;
                for (int k = 0; k < 270; k++) begin
                    send_item(OP_PACKET, make_item(seq, pick_len(), RADDR_W'($urandom)));
                    seq = seq + 1'b1;
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15)      resync = 8'd1;
                else if (r < 40) resync = 8'd255;
                else if (r < 45) resync = 8'd0;
                else             resync = IDX_W'($urandom_range(2, 254));
                r = $urandom_range(0, 99);
                if (r < 15)      len = 8'd0;
                else if (r < 35) len = 8'd128;
                else if (r < 45) len = 8'd255;
                else if (r < 80) len = CFG_DATA_W'($urandom_range(1, 40));
                else             len = CFG_DATA_W'($urandom_range(0, 255));
                configure(resync, len);

                // mostly in-order packet runs, with finals, restarts, resyncs and noise
                count = $urandom_range(30, 150);
                seq = FIRST_IDX;
                fin = 1'b0;
                for (int k = 0; k < count; k++) begin
                    r = $urandom_range(0, 99);
                    if (r == 0) drain();
                    if (fin && r < 80) begin
                        send_item(OP_UNLOCK, rand_item());
                        fin = 1'b0;
                        seq = FIRST_IDX;
                    end else if (r < 68) begin
                        send_item(OP_PACKET, make_item(seq, pick_len(), RADDR_W'($urandom)));
                        seq = (seq == resync) ? FIRST_IDX : seq + 1'b1;
                    end else if (r < 74) begin
                        send_item(OP_PACKET, make_item(8'd0, pick_len(), RADDR_W'($urandom)));
                        if (seq > FIRST_IDX) fin = 1'b1;
                        seq = FIRST_IDX;
                    end else if (r < 78) begin
                        send_item(OP_PACKET,
                                  make_item(FIRST_IDX, pick_len(), RADDR_W'($urandom)));
                        seq = FIRST_IDX + 1'b1;
                    end else if (r < 81) begin
                        send_item(OP_PACKET, make_item(resync, pick_len(), RADDR_W'($urandom)));
                        seq = FIRST_IDX;
                        fin = 1'b0;
                    end else if (r < 87) begin
                        send_item(OP_READ, rand_item());
                    end else if (r < 90) begin
                        send_item(OP_RESET, rand_item());
                        seq = FIRST_IDX;
                    end else if (r < 93) begin
                        send_item(OP_UNLOCK, rand_item());
                        if (fin) seq = FIRST_IDX;
                        fin = 1'b0;
                    end else begin
                        send_item(t_op'($urandom_range(0, 3)), rand_item());
                    end
                end
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
